FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the hash map block; the back part includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/chmc_pkg.sv
// Package with command codes and request types of the hash map block.
`timescale 1ns / 1ps
package chmc_pkg;
   localparam logic [2:0] CMD_PUT = 3'd0;
   localparam logic [2:0] CMD_GET = 3'd1;
   localparam logic [2:0] CMD_DEL = 3'd2;
   localparam logic [2:0] CMD_CLR = 3'd3;
   localparam logic [2:0] CMD_ADD = 3'd4;

   // Classified request as handed from the front to the back.
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] key;
      logic [31:0] value;
      logic [31:0] mag;
   } req_type;
endpackage

FILE: rtl/core/chmc_front.sv
// Front part: accepts requests, computes the key magnitude and queues them.
`timescale 1ns / 1ps
module chmc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2:0]       cmd,
   input  logic [31:0]      key,
   input  logic [31:0]      value,
   input  logic             pop,
   output logic             busy,
   output logic             q_valid,
   output chmc_pkg::req_type q_data
);
   chmc_pkg::req_type slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push;
   chmc_pkg::req_type item;

   // Classify the request: absolute value of the key.
   always_comb begin
      item.cmd   = cmd;
      item.key   = key;
      item.value = value;
      item.mag   = key[31] ? (32'd0 - key) : key;
   end

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(pop && q_valid)) cnt_in = cnt_ff + 2'd1;
      else if (!push && pop && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   // Two-entry queue between front and back.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop && q_valid) rd_ff <= !rd_ff;
      end
      if (push) slot_ff[wr_ff] <= item;
   end
endmodule

FILE: rtl/core/chmc_back.sv
// Back part: walks bucket chains in memory and carries out each request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chmc_back #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  chmc_pkg::req_type q_data,
   output logic              pop,
   output logic              rsp_valid,
   output logic              rsp_found,
   output logic [31:0]       rsp_result_value,
   output logic              rsp_status
);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);
   localparam logic [LW:0]   LIMIT = (LW + 1)'(ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_HEAD, S_HWAIT, S_WALK, S_WWAIT, S_CHECK, S_ACT, S_ALLOC, S_DONE
   } state_type;

   // Memories.
   logic [LW-1:0] heads [BUCKETS];
   logic [31:0]   keys_m [ENTRIES];
   logic [31:0]   vals_m [ENTRIES];
   logic [LW-1:0] links_m [ENTRIES];

   state_type      state_ff;
   chmc_pkg::req_type req_ff;
   logic [BW-1:0]  bkt_ff;
   logic [LW-1:0]  cur_ff, prev_ff, free_ff, fresh_ff, total_ff;
   logic [LW:0]    steps_ff;
   logic [31:0]    rkey_ff, rval_ff;
   logic [LW-1:0]  rlink_ff, hd_ff, flink_ff;
   logic           found_ff, status_ff;
   logic [31:0]    res_ff;
   logic           vld_ff;
   logic [BW-1:0]  clr_ff;
   logic [BW-1:0]  bkt_in;

   assign bkt_in = (BUCKETS > 1) ? BW'(q_data.mag % BUCKETS) : '0;
   assign pop    = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid        = vld_ff;
   assign rsp_found        = found_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = status_ff;

   // Registered memory reads of the current slot, the free head and the bucket head.
   always_ff @(posedge clock) begin
      rkey_ff  <= keys_m[cur_ff[AW-1:0]];
      rval_ff  <= vals_m[cur_ff[AW-1:0]];
      rlink_ff <= links_m[cur_ff[AW-1:0]];
      flink_ff <= links_m[free_ff[AW-1:0]];
      hd_ff    <= heads[bkt_ff];
   end

   // Request sequencer with clear sweep after reset and on clear.
   always_ff @(posedge clock) begin
      vld_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         free_ff  <= NIL;
         fresh_ff <= '0;
         total_ff <= '0;
         cur_ff   <= '0;
      end else begin
         case (state_ff)
            S_CLR: begin
               heads[clr_ff] <= NIL;
               clr_ff <= clr_ff + BW'(1);
               if (32'(clr_ff) == BUCKETS - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid) begin
                  req_ff   <= q_data;
                  bkt_ff   <= bkt_in;
                  found_ff <= 1'b0;
                  status_ff <= 1'b0;
                  res_ff   <= '0;
                  prev_ff  <= NIL;
                  steps_ff <= '0;
                  if (q_data.cmd == chmc_pkg::CMD_CLR) begin
                     free_ff  <= NIL;
                     fresh_ff <= '0;
                     total_ff <= '0;
                     clr_ff   <= '0;
                     vld_ff   <= 1'b1;
                     state_ff <= S_CLR;
                  end else if (q_data.cmd > chmc_pkg::CMD_ADD) begin
                     vld_ff   <= 1'b1;
                  end else begin
                     state_ff <= S_HEAD;
                  end
               end
            end
            S_HEAD: state_ff <= S_HWAIT;
            S_HWAIT: begin
               cur_ff   <= hd_ff;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (cur_ff >= NIL || steps_ff >= LIMIT) state_ff <= S_ACT;
               else state_ff <= S_WWAIT;
            end
            S_WWAIT: state_ff <= S_CHECK;
            S_CHECK: begin
               if (rkey_ff == req_ff.key) begin
                  found_ff <= 1'b1;
                  state_ff <= S_ACT;
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= rlink_ff;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_WALK;
               end
            end
            S_ACT: begin
               state_ff <= S_DONE;
               if (found_ff) begin
                  case (req_ff.cmd)
                     chmc_pkg::CMD_PUT: vals_m[cur_ff[AW-1:0]] <= req_ff.value;
                     chmc_pkg::CMD_GET: res_ff <= rval_ff;
                     chmc_pkg::CMD_ADD: begin
                        vals_m[cur_ff[AW-1:0]] <= rval_ff + req_ff.value;
                        res_ff <= rval_ff + req_ff.value;
                     end
                     chmc_pkg::CMD_DEL: begin
                        if (prev_ff < NIL) links_m[prev_ff[AW-1:0]] <= rlink_ff;
                        else heads[bkt_ff] <= rlink_ff;
                        state_ff <= S_ALLOC;
                     end
                     default: ;
                  endcase
               end else if (req_ff.cmd == chmc_pkg::CMD_PUT
                            || req_ff.cmd == chmc_pkg::CMD_ADD) begin
                  if (free_ff < NIL) begin
                     cur_ff  <= free_ff;
                     free_ff <= flink_ff;
                     state_ff <= S_ALLOC;
                  end else if (fresh_ff < NIL) begin
                     cur_ff   <= fresh_ff;
                     fresh_ff <= fresh_ff + 1'b1;
                     state_ff <= S_ALLOC;
                  end else begin
                     status_ff <= 1'b1;
                  end
               end
            end
            S_ALLOC: begin
               state_ff <= S_DONE;
               if (found_ff) begin
                  // Delete: push the slot onto the free list.
                  links_m[cur_ff[AW-1:0]] <= free_ff;
                  free_ff <= cur_ff;
                  if (total_ff != '0) total_ff <= total_ff - 1'b1;
               end else begin
                  keys_m[cur_ff[AW-1:0]]  <= req_ff.key;
                  vals_m[cur_ff[AW-1:0]]  <= req_ff.value;
                  links_m[cur_ff[AW-1:0]] <= hd_ff;
                  heads[bkt_ff] <= cur_ff;
                  total_ff <= total_ff + 1'b1;
                  if (req_ff.cmd == chmc_pkg::CMD_ADD) res_ff <= req_ff.value;
               end
            end
            S_DONE: begin
               vld_ff   <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_full_no_found, clock, reset, vld_ff && status_ff, !found_ff, "full with found")
   `ASSERT_IMPL(a_total_bound, clock, reset, 1'b1, total_ff <= NIL, "entry total exceeds pool")
   `ASSERT_IMPL(a_fresh_bound, clock, reset, 1'b1, fresh_ff <= NIL, "fresh count exceeds pool")
   `ASSERT_NEXT(a_pop_leaves_idle, clock, reset, pop && q_data.cmd <= chmc_pkg::CMD_ADD
                && q_data.cmd != chmc_pkg::CMD_CLR, state_ff == S_HEAD, "request not taken")
endmodule

FILE: rtl/core/chained_hash_map_with_counts.sv
// Top level of the chained hash map with counts.
`timescale 1ns / 1ps
// Usage: a request (req_cmd, req_key, req_value) is taken on a clock edge
// where start is high and busy is low. Commands are put, get, delete, clear
// and add to count. Each request gives exactly one response, shown on the
// rsp_ ports for one cycle while rsp_valid is high; the receiver cannot stall.
// A two-entry queue lets new requests enter while the back part works.
// The back part serves one request at a time: it reads the bucket head,
// walks the chain through the entry memory one slot after another, acts
// on the slot found; an insert or delete then updates the links. Clear
// sweeps the bucket head memory, one bucket per cycle, and its response
// comes at the start. After reset the same sweep runs before the first
// request is served; requests may queue meanwhile.
module chained_hash_map_with_counts #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic signed [31:0] rsp_result_value,
   output logic        rsp_status
);
   logic q_valid, pop;
   chmc_pkg::req_type q_data;
   logic [31:0] res;

   chmc_front u_front (
      .clock(clock), .reset(reset), .start(start),
      .cmd(req_cmd), .key(req_key), .value(req_value),
      .pop(pop), .busy(busy), .q_valid(q_valid), .q_data(q_data)
   );

   chmc_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_found(rsp_found),
      .rsp_result_value(res), .rsp_status(rsp_status)
   );

   assign rsp_result_value = res;
endmodule

FILE: sim/tb_chained_hash_map_with_counts.sv
// Self-checking testbench for the chained hash map with counts.
`timescale 1ns / 1ps
module tb_chained_hash_map_with_counts;

   localparam int NUM_BUCKETS = 256;
   localparam int NUM_SLOTS = 1024;
   localparam int unsigned NO_SLOT = NUM_SLOTS;
   localparam int CYCLE_LIMIT = 1500000;
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;
   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

   typedef struct {
      logic        found;
      logic [31:0] value;
      logic        status;
   } answer_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] key;
      logic [31:0] value;
      bit          typed;
      answer_type  ans;
   } stim_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_cmd;
   logic signed [31:0] req_key;
   logic signed [31:0] req_value;
   logic rsp_valid;
   logic rsp_found;
   logic signed [31:0] rsp_result_value;
   logic rsp_status;

   // Shadow copy of the hash map.
   int unsigned bucket_head[NUM_BUCKETS];
   logic [31:0] slot_key[NUM_SLOTS];
   logic [31:0] slot_value[NUM_SLOTS];
   int unsigned slot_link[NUM_SLOTS];
   int unsigned free_top;
   int unsigned fresh_next;
   int unsigned live_entries;

   answer_type pending_answers[$];
   int error_count = 0;
   int cycle_count = 0;
   bit steady_stretch = 0;

   chained_hash_map_with_counts dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Empties the shadow map, as reset and clear do.
   function automatic void map_clear();
      foreach (bucket_head[i]) bucket_head[i] = NO_SLOT;
      free_top = NO_SLOT;
      fresh_next = 0;
      live_entries = 0;
   endfunction

   // Bucket from the unsigned magnitude of the key.
   function automatic int unsigned bucket_of_key(logic [31:0] k);
      logic [31:0] mag;
      mag = k[31] ? (32'd0 - k) : k;
      return mag % NUM_BUCKETS;
   endfunction

   // Walks one chain; returns the slot holding the key or NO_SLOT.
   function automatic int unsigned chain_lookup(int unsigned b, logic [31:0] k,
                                                output int unsigned prev);
      int unsigned cur;
      int unsigned steps;
      cur = bucket_head[b];
      prev = NO_SLOT;
      steps = 0;
      while (cur < NO_SLOT && steps < NUM_SLOTS) begin
         if (slot_key[cur] == k) return cur;
         prev = cur;
         cur = slot_link[cur];
         steps++;
      end
      return NO_SLOT;
   endfunction

   // Takes a slot from the free list first, then from the unused region.
   function automatic int unsigned slot_take();
      int unsigned s;
      if (free_top < NO_SLOT) begin
         s = free_top;
         free_top = slot_link[s];
         return s;
      end
      if (fresh_next < NO_SLOT) begin
         fresh_next++;
         return fresh_next - 1;
      end
      return NO_SLOT;
   endfunction

   function automatic int unsigned chain_insert(int unsigned b, logic [31:0] k,
                                                logic [31:0] v);
      int unsigned s;
      s = slot_take();
      if (s >= NO_SLOT) return NO_SLOT;
      slot_key[s] = k;
      slot_value[s] = v;
      slot_link[s] = bucket_head[b];
      bucket_head[b] = s;
      live_entries++;
      return s;
   endfunction

   // Applies one request to the shadow map and returns its response.
   function automatic answer_type map_apply(logic [2:0] cmd, logic [31:0] k,
                                            logic [31:0] v);
      answer_type a;
      int unsigned b;
      int unsigned prev;
      int unsigned s;
      a.found = 1'b0;
      a.value = '0;
      a.status = 1'b0;
      b = bucket_of_key(k);
      case (cmd)
         chmc_pkg::CMD_PUT: begin
            s = chain_lookup(b, k, prev);
            if (s < NO_SLOT) begin
               a.found = 1'b1;
               slot_value[s] = v;
            end else if (chain_insert(b, k, v) >= NO_SLOT) begin
               a.status = 1'b1;
            end
         end
         chmc_pkg::CMD_GET: begin
            s = chain_lookup(b, k, prev);
            if (s < NO_SLOT) begin
               a.found = 1'b1;
               a.value = slot_value[s];
            end
         end
         chmc_pkg::CMD_DEL: begin
            s = chain_lookup(b, k, prev);
            if (s < NO_SLOT) begin
               a.found = 1'b1;
               if (prev < NO_SLOT) slot_link[prev] = slot_link[s];
               else bucket_head[b] = slot_link[s];
               slot_link[s] = free_top;
               free_top = s;
               if (live_entries > 0) live_entries--;
            end
         end
         chmc_pkg::CMD_CLR: map_clear();
         chmc_pkg::CMD_ADD: begin
            s = chain_lookup(b, k, prev);
            if (s < NO_SLOT) begin
               a.found = 1'b1;
               slot_value[s] = slot_value[s] + v;
               a.value = slot_value[s];
            end else begin
               s = chain_insert(b, k, v);
               if (s < NO_SLOT) a.value = slot_value[s];
               else a.status = 1'b1;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // Gap after a request: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (steady_stretch) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Issues one request and records its expected response. The request is
   // taken at the first rising edge where busy was low just before it.
   task automatic send_request(logic [2:0] cmd, logic [31:0] k, logic [31:0] v,
                               bit typed, answer_type typed_ans);
      answer_type a;
      int gap;
      bit taken;
      req_cmd <= cmd;
      req_key <= k;
      req_value <= v;
      start <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      a = map_apply(cmd, k, v);
      pending_answers.push_back(typed ? typed_ans : a);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_checked(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
      answer_type none;
      none = '{1'b0, 32'd0, 1'b0};
      send_request(cmd, k, v, 1'b0, none);
   endtask

   // Holds the sender off until every response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Keys that mostly collide in a few buckets so chains grow deep.
   function automatic logic [31:0] pick_key();
      int r;
      logic [31:0] k;
      r = $urandom_range(99);
      if (r < 15) return $urandom();
      if (r < 18) return ($urandom_range(1)) ? INT_MIN : INT_MAX;
      k = $urandom_range(7) * NUM_BUCKETS + $urandom_range(3);
      return ($urandom_range(1)) ? (32'd0 - k) : k;
   endfunction

   function automatic logic [2:0] pick_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 30) return chmc_pkg::CMD_PUT;
      if (r < 55) return chmc_pkg::CMD_GET;
      if (r < 72) return chmc_pkg::CMD_DEL;
      if (r < 94) return chmc_pkg::CMD_ADD;
      if (r < 96) return chmc_pkg::CMD_CLR;
      case ($urandom_range(2))
         0: return CMD_RSVD5;
         1: return CMD_RSVD6;
         default: return CMD_RSVD7;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom_range(20) - 10;
      return $urandom();
   endfunction

   task automatic mixed_traffic(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(49) == 0) steady_stretch = ~steady_stretch;
         send_checked(pick_cmd(), pick_key(), pick_value());
      end
      steady_stretch = 0;
   endtask

   // Response checker: the receiver never stalls.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: response with none expected: found %0b value %h status %0b",
                     $time, rsp_found, rsp_result_value, rsp_status);
            error_count++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_found !== e.found) begin
               $display("%0t: found expected %0b actual %0b", $time, e.found, rsp_found);
               error_count++;
            end
            if (rsp_result_value !== e.value) begin
               $display("%0t: result_value expected %h actual %h",
                        $time, e.value, rsp_result_value);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0b actual %0b", $time, e.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_answers.size());
         $display("tb_chained_hash_map_with_counts: errors");
         $finish;
      end
   end

   // Directed table, then random traffic, a pool fill and more traffic.
   initial begin
      stim_row_type rows[$];
      int settle;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = chmc_pkg::CMD_GET;
      req_key = '0;
      req_value = '0;
      map_clear();

      rows.push_back('{chmc_pkg::CMD_GET, 32'd5, 32'd0, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, 32'd5, 32'd100, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_GET, 32'd5, 32'd0, 1, '{1, 32'd100, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, 32'd5, 32'hffff_ffff, 1, '{1, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_GET, 32'hffff_fffb, 32'd0, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_ADD, 32'hffff_fffb, 32'd7, 1, '{0, 32'd7, 0}});
      rows.push_back('{chmc_pkg::CMD_ADD, 32'hffff_fffb, INT_MAX, 1,
                       '{1, 32'h8000_0006, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, INT_MIN, INT_MIN, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, 32'd0, INT_MAX, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, 32'd256, 32'd3, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_GET, INT_MIN, 32'd0, 1, '{1, INT_MIN, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, INT_MAX, 32'd1, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_DEL, 32'd0, 32'd0, 1, '{1, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_GET, 32'd256, 32'd0, 1, '{1, 32'd3, 0}});
      rows.push_back('{chmc_pkg::CMD_DEL, 32'd5, 32'd0, 1, '{1, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_DEL, 32'd5, 32'd0, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_PUT, 32'd777, 32'h1234_5678, 0, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_ADD, INT_MAX, INT_MIN, 1, '{1, 32'h8000_0001, 0}});
      rows.push_back('{CMD_RSVD5, 32'd256, 32'd9, 1, '{0, 32'd0, 0}});
      rows.push_back('{CMD_RSVD6, INT_MIN, 32'd9, 1, '{0, 32'd0, 0}});
      rows.push_back('{CMD_RSVD7, 32'd0, 32'd9, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_CLR, 32'd0, 32'd0, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_GET, INT_MIN, 32'd0, 1, '{0, 32'd0, 0}});
      rows.push_back('{chmc_pkg::CMD_ADD, 32'd256, 32'hffff_fffe, 1,
                       '{0, 32'hffff_fffe, 0}});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_request(rows[i].cmd, rows[i].key, rows[i].value,
                                     rows[i].typed, rows[i].ans);
      drain_responses();
      mixed_traffic(200);
      drain_responses();

      // Fill the whole pool, then send puts and adds, those on new keys to be refused.
      send_checked(chmc_pkg::CMD_CLR, $urandom(), $urandom());
      for (int i = 0; i < NUM_SLOTS; i++)
         send_checked(($urandom_range(1)) ? chmc_pkg::CMD_PUT : chmc_pkg::CMD_ADD,
                      ($urandom_range(1)) ? 32'd10000 + i : 32'd0 - (32'd10000 + i),
                      pick_value());
      for (int i = 0; i < 30; i++)
         send_checked(($urandom_range(2) == 0) ? chmc_pkg::CMD_ADD : chmc_pkg::CMD_PUT,
                      ($urandom_range(1)) ? 32'd20000 + i
                                          : 32'd10000 + $urandom_range(NUM_SLOTS - 1),
                      pick_value());
      // Free a few slots and reuse them through the free list.
      for (int i = 0; i < 40; i++)
         send_checked(($urandom_range(1)) ? chmc_pkg::CMD_DEL : chmc_pkg::CMD_PUT,
                      32'd10000 + $urandom_range(60), pick_value());
      drain_responses();
      send_checked(chmc_pkg::CMD_CLR, 32'd0, 32'd0);
      mixed_traffic(100);
      drain_responses();

      settle = 0;
      while (settle < 300) begin
         @(posedge clock);
         settle++;
      end
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("tb_chained_hash_map_with_counts: clean");
      end else begin
         $display("tb_chained_hash_map_with_counts: errors");
      end
      $finish;
   end
endmodule
